### rtl/battery_slot_health_summary_defines.svh
// ---------------------------------------------------------------------------
// Battery slot health summary assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef BATTERY_SLOT_HEALTH_SUMMARY_DEFINES_SVH
`define BATTERY_SLOT_HEALTH_SUMMARY_DEFINES_SVH

// same-cycle implication
`define BSH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsh check failed");

// next-cycle implication
`define BSH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsh check failed");

`endif

### rtl/bsh_pkg.sv
// ---------------------------------------------------------------------------
// Battery slot health summary package
// Field widths, reset values and codes shared by the block's files.
// ---------------------------------------------------------------------------
package bsh_pkg;

    localparam int DATA_W     = 16;
    localparam int TIME_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int LIMIT_W    = 8;
    localparam int COUNT_W    = 5;
    localparam int LOW_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] ERR_LIMIT_RST = 8'd5;
    localparam logic [LIMIT_W-1:0] ERR_MAX       = 8'd255;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST   = 32'd3000;
    localparam logic [LOW_W-1:0]   CHARGE_CAP    = 7'd100;

    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_ROUND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_TIMEOUT = 1'b1;

endpackage

### rtl/bsh_in_if.sv
// ---------------------------------------------------------------------------
// Battery slot health input channel
// Valid/ready channel carrying one poll result or round-end beat.
// ---------------------------------------------------------------------------
interface bsh_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [bsh_pkg::SLOT_W-1:0]  slot_index;
    logic                        read_ok;
    logic [bsh_pkg::DATA_W-1:0]  pack_voltage;
    logic [bsh_pkg::DATA_W-1:0]  pack_temperature;
    logic [bsh_pkg::DATA_W-1:0]  charge_percent;
    logic [bsh_pkg::DATA_W-1:0]  alarm_word;
    logic [bsh_pkg::DATA_W-1:0]  fault_word;
    logic [bsh_pkg::TIME_W-1:0]  now_ms;

    modport source (
        output valid, opcode, slot_index, read_ok, pack_voltage, pack_temperature,
               charge_percent, alarm_word, fault_word, now_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot_index, read_ok, pack_voltage, pack_temperature,
               charge_percent, alarm_word, fault_word, now_ms,
        output ready
    );
endinterface

### rtl/bsh_out_if.sv
// ---------------------------------------------------------------------------
// Battery slot health output channel
// Valid/ready channel carrying one summary beat.
// ---------------------------------------------------------------------------
interface bsh_out_if;
    logic                        valid;
    logic                        ready;
    logic [bsh_pkg::COUNT_W-1:0] online_count;
    logic [bsh_pkg::DATA_W-1:0]  average_voltage;
    logic [bsh_pkg::DATA_W-1:0]  average_temperature;
    logic [bsh_pkg::LOW_W-1:0]   lowest_charge;
    logic [bsh_pkg::DATA_W-1:0]  highest_charge;
    logic [bsh_pkg::DATA_W-1:0]  alarm_mask;
    logic [bsh_pkg::DATA_W-1:0]  fault_mask;
    logic                        running;

    modport source (
        output valid, online_count, average_voltage, average_temperature,
               lowest_charge, highest_charge, alarm_mask, fault_mask, running,
        input  ready
    );
    modport sink (
        input  valid, online_count, average_voltage, average_temperature,
               lowest_charge, highest_charge, alarm_mask, fault_mask, running,
        output ready
    );
endinterface

### rtl/bsh_div.sv
// ---------------------------------------------------------------------------
// Battery slot health divider
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ---------------------------------------------------------------------------
module bsh_div #(
    parameter int CW = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [bsh_pkg::DATA_W+CW-1:0]        dividend,
    input  logic [CW-1:0]                        divisor,
    output logic [bsh_pkg::DATA_W-1:0]           quotient,
    output logic                                 done
);

    localparam int QW    = bsh_pkg::DATA_W;
    localparam int SW    = QW + CW;
    localparam int STEPW = $clog2(QW);
    localparam logic [STEPW-1:0] LAST_STEP = STEPW'(QW - 1);

    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    rem_next;
    logic [QW-1:0]    dq_reg;
    logic [CW-1:0]    div_reg;
    logic [STEPW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             ge;

    // top part of the dividend is already below the divisor
    assign trial    = {rem_reg, dq_reg[QW-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[SW-1:QW];
            dq_reg  <= dividend[QW-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[QW-2:0], ge};
        end
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

### rtl/battery_slot_health_summary.sv
// ---------------------------------------------------------------------------
// Battery slot health summary
// Slot table updated by poll results, summarized at each round end.
// ---------------------------------------------------------------------------
// A poll-result beat is captured, then applied to its slot. In a round-end
// beat the scan visits one slot per cycle (timeout drop and accumulation
// together), then one 16-step restoring divider forms the voltage average
// and then the temperature average. With no slot online the divider is
// skipped. The block takes no new beat while a beat is in work; a finished
// summary sits in the output register and the next beat is accepted
// meanwhile. No clearing pass follows reset.
module battery_slot_health_summary #(
    parameter int SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bsh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    bsh_in_if.sink                            item,
    bsh_out_if.source                         result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = bsh_pkg::DATA_W + CW;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_POLL   = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_PREP   = 7'b0001000,
        ST_DIV_V  = 7'b0010000,
        ST_DIV_T  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [bsh_pkg::LIMIT_W-1:0] err_limit_reg;
    logic [bsh_pkg::TIME_W-1:0]  timeout_reg;

    // captured beat
    logic [bsh_pkg::SLOT_W-1:0]  slot_reg;
    logic                        ok_reg;
    logic [bsh_pkg::DATA_W-1:0]  volt_in_reg;
    logic [bsh_pkg::DATA_W-1:0]  temp_in_reg;
    logic [bsh_pkg::DATA_W-1:0]  chg_in_reg;
    logic                        alarm_in_reg;
    logic                        fault_in_reg;
    logic [bsh_pkg::TIME_W-1:0]  now_reg;

    // slot table
    logic                        online_reg [SLOTS];
    logic [bsh_pkg::LIMIT_W-1:0] err_reg    [SLOTS];
    logic [bsh_pkg::TIME_W-1:0]  stamp_reg  [SLOTS];
    logic [bsh_pkg::DATA_W-1:0]  volt_reg   [SLOTS];
    logic [bsh_pkg::DATA_W-1:0]  temp_reg   [SLOTS];
    logic [bsh_pkg::DATA_W-1:0]  chg_reg    [SLOTS];
    logic                        alarm_reg  [SLOTS];
    logic                        fault_reg  [SLOTS];

    // scan accumulators
    logic [IW-1:0]               cnt_reg;
    logic [CW-1:0]               on_cnt_reg;
    logic [SW-1:0]               sumv_reg;
    logic [SW-1:0]               sumt_reg;
    logic [bsh_pkg::LOW_W-1:0]   lo_reg;
    logic [bsh_pkg::DATA_W-1:0]  hi_reg;
    logic [SLOTS-1:0]            amask_reg;
    logic [SLOTS-1:0]            fmask_reg;
    logic [bsh_pkg::DATA_W-1:0]  avgv_reg;

    // output register
    logic                        out_valid_reg;
    logic [bsh_pkg::COUNT_W-1:0] o_count_reg;
    logic [bsh_pkg::DATA_W-1:0]  o_avgv_reg;
    logic [bsh_pkg::DATA_W-1:0]  o_avgt_reg;
    logic [bsh_pkg::LOW_W-1:0]   o_lo_reg;
    logic [bsh_pkg::DATA_W-1:0]  o_hi_reg;
    logic [SLOTS-1:0]            o_amask_reg;
    logic [SLOTS-1:0]            o_fmask_reg;

    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic                        slot_in_range;
    logic [IW-1:0]               slot_sel;
    logic [IW-1:0]               rd_idx;
    logic                        rd_online;
    logic [bsh_pkg::LIMIT_W-1:0] rd_err;
    logic [bsh_pkg::LIMIT_W-1:0] err_inc;
    logic                        err_drop;
    logic [bsh_pkg::TIME_W-1:0]  age;
    logic                        expired;
    logic                        live;
    logic                        poll_wr;
    logic                        scan_step;
    logic                        any_online;
    logic                        div_start;
    logic [SW-1:0]               div_dividend;
    logic [bsh_pkg::DATA_W-1:0]  div_quot;
    logic                        div_done;

    assign accept   = item.valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || result.ready;
    assign load_out = (state_reg == ST_FINISH) && out_free;

    assign slot_in_range = {1'b0, slot_reg} < bsh_pkg::COUNT_W'(SLOTS);
    assign slot_sel      = slot_reg[IW-1:0];
    assign rd_idx        = (state_reg == ST_POLL) ? slot_sel : cnt_reg;

    assign rd_online = online_reg[rd_idx];
    assign rd_err    = err_reg[rd_idx];
    assign err_inc   = (rd_err == bsh_pkg::ERR_MAX) ? rd_err : rd_err + 1'b1;
    assign err_drop  = err_inc >= err_limit_reg;

    assign age       = now_reg - stamp_reg[rd_idx];
    assign expired   = rd_online && (age > timeout_reg);
    assign live      = rd_online && !expired;

    assign poll_wr    = (state_reg == ST_POLL) && slot_in_range;
    assign scan_step  = state_reg == ST_SCAN;
    assign any_online = on_cnt_reg != '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                    state_next = (item.opcode == bsh_pkg::OP_ROUND) ? ST_SCAN : ST_POLL;
            end
            ST_POLL:
                state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (cnt_reg == LAST_SLOT)
                    state_next = ST_PREP;
            end
            ST_PREP:
                state_next = any_online ? ST_DIV_V : ST_FINISH;
            ST_DIV_V:
            begin
                if (div_done)
                    state_next = ST_DIV_T;
            end
            ST_DIV_T:
            begin
                if (div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_step)
                cnt_reg <= (cnt_reg == LAST_SLOT) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_limit_reg <= bsh_pkg::ERR_LIMIT_RST;
            timeout_reg   <= bsh_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsh_pkg::REG_ERROR_LIMIT:
                    err_limit_reg <= cfg_wdata[bsh_pkg::LIMIT_W-1:0];
                bsh_pkg::REG_OFFLINE_TIMEOUT:
                    timeout_reg <= cfg_wdata[bsh_pkg::TIME_W-1:0];
                default:
                    timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg     <= item.slot_index;
            ok_reg       <= item.read_ok;
            volt_in_reg  <= item.pack_voltage;
            temp_in_reg  <= item.pack_temperature;
            chg_in_reg   <= item.charge_percent;
            alarm_in_reg <= item.alarm_word != '0;
            fault_in_reg <= item.fault_word != '0;
            now_reg      <= item.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                online_reg[i] <= 1'b0;
                err_reg[i]    <= '0;
            end
        end
        else if (poll_wr)
        begin
            if (ok_reg)
            begin
                online_reg[slot_sel] <= 1'b1;
                err_reg[slot_sel]    <= '0;
            end
            else
            begin
                err_reg[slot_sel] <= err_inc;
                if (err_drop)
                    online_reg[slot_sel] <= 1'b0;
            end
        end
        else if (scan_step && expired)
        begin
            online_reg[cnt_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_wr && ok_reg)
        begin
            stamp_reg[slot_sel] <= now_reg;
            volt_reg[slot_sel]  <= volt_in_reg;
            temp_reg[slot_sel]  <= temp_in_reg;
            chg_reg[slot_sel]   <= chg_in_reg;
            alarm_reg[slot_sel] <= alarm_in_reg;
            fault_reg[slot_sel] <= fault_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            on_cnt_reg <= '0;
            sumv_reg   <= '0;
            sumt_reg   <= '0;
            lo_reg     <= bsh_pkg::CHARGE_CAP;
            hi_reg     <= '0;
            amask_reg  <= '0;
            fmask_reg  <= '0;
        end
        else if (scan_step && live)
        begin
            on_cnt_reg         <= on_cnt_reg + 1'b1;
            sumv_reg           <= sumv_reg + SW'(volt_reg[cnt_reg]);
            sumt_reg           <= sumt_reg + SW'(temp_reg[cnt_reg]);
            amask_reg[cnt_reg] <= alarm_reg[cnt_reg];
            fmask_reg[cnt_reg] <= fault_reg[cnt_reg];
            if (chg_reg[cnt_reg] < bsh_pkg::DATA_W'(lo_reg))
                lo_reg <= chg_reg[cnt_reg][bsh_pkg::LOW_W-1:0];
            if (chg_reg[cnt_reg] > hi_reg)
                hi_reg <= chg_reg[cnt_reg];
        end
    end

    assign div_start    = ((state_reg == ST_PREP) && any_online)
                       || ((state_reg == ST_DIV_V) && div_done);
    assign div_dividend = (state_reg == ST_PREP) ? sumv_reg : sumt_reg;

    bsh_div #(
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (on_cnt_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV_V) && div_done)
            avgv_reg <= div_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_count_reg <= bsh_pkg::COUNT_W'(on_cnt_reg);
            o_avgv_reg  <= any_online ? avgv_reg : '0;
            o_avgt_reg  <= any_online ? div_quot : '0;
            o_lo_reg    <= any_online ? lo_reg : '0;
            o_hi_reg    <= any_online ? hi_reg : '0;
            o_amask_reg <= amask_reg;
            o_fmask_reg <= fmask_reg;
        end
    end

    assign item.ready                 = state_reg == ST_IDLE;
    assign result.valid               = out_valid_reg;
    assign result.online_count        = o_count_reg;
    assign result.average_voltage     = o_avgv_reg;
    assign result.average_temperature = o_avgt_reg;
    assign result.lowest_charge       = o_lo_reg;
    assign result.highest_charge      = o_hi_reg;
    assign result.alarm_mask          = bsh_pkg::DATA_W'(o_amask_reg);
    assign result.fault_mask          = bsh_pkg::DATA_W'(o_fmask_reg);
    assign result.running             = o_count_reg != '0;

endmodule

### rtl/bsh_chk.sv
// ---------------------------------------------------------------------------
// Battery slot health port checker
// Port-level checks on beat flow and summary consistency, bound to the top.
// ---------------------------------------------------------------------------
`include "battery_slot_health_summary_defines.svh"

module bsh_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [bsh_pkg::COUNT_W-1:0]       online_count,
    input logic [bsh_pkg::DATA_W-1:0]        average_voltage,
    input logic [bsh_pkg::LOW_W-1:0]         lowest_charge,
    input logic [bsh_pkg::DATA_W-1:0]        highest_charge,
    input logic                              running
);

    // held summary beat stays up
    `BSH_ASSERT_NXT(a_out_hold, result_valid && !result_ready, result_valid)

    // one beat at a time
    `BSH_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready)

    `BSH_ASSERT_IMP(a_running, result_valid, running == (online_count != '0))

    `BSH_ASSERT_IMP(a_empty_zero, result_valid && (online_count == '0),
        average_voltage == '0 && lowest_charge == '0 && highest_charge == '0)

    `BSH_ASSERT_IMP(a_low_cap, result_valid, lowest_charge <= bsh_pkg::CHARGE_CAP)

endmodule

bind battery_slot_health_summary bsh_chk u_bsh_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .online_count    (result.online_count),
    .average_voltage (result.average_voltage),
    .lowest_charge   (result.lowest_charge),
    .highest_charge  (result.highest_charge),
    .running         (result.running)
);
